FILE: rtl/core/met_pkg.sv
package met_pkg;

   localparam int COUNT_W    = 16;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam int PIXEL_W    = 10;
   localparam int SIZE_W     = 11;
   localparam int STEP_W     = 28;
   localparam int OFFS_W     = 12;

   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_X   = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CENTER_Y   = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_PIXEL_STEP = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ITER_LIMIT = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_W   = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SCREEN_H   = 3'd5;

   localparam logic [STEP_W-1:0]  RST_PIXEL_STEP = 28'd1879048;
   localparam logic [COUNT_W-1:0] RST_ITER_LIMIT = 16'd200;
   localparam logic [SIZE_W-1:0]  RST_SCREEN_W   = 11'd640;
   localparam logic [SIZE_W-1:0]  RST_SCREEN_H   = 11'd480;

   typedef struct packed {
      logic [PIXEL_W-1:0] column;
      logic [PIXEL_W-1:0] row;
   } met_req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] iterations;
      logic               in_set;
   } met_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_RE,
      ST_MAP_IM,
      ST_MAP_FIN,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_CROSS,
      ST_UPDATE
   } met_state_type;

endpackage

FILE: rtl/core/mandelbrot_escape_time_unit.sv
// Escape-time engine: one pixel request at a time through one shared signed multiplier.
// Steps: 2 mapping products and a saturation step, then 3 products and an update step per
// pass (no pass with a zero limit); a finished result waits while a stalled earlier result
// still holds the output register. A new request is taken only back in ST_IDLE.
// Reset (synchronous, active high) loads the default view and clears control state.
module mandelbrot_escape_time_unit #(
   parameter int FRAC_BITS   = 28,
   parameter int COORD_WIDTH = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  met_pkg::met_req_type                 req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output met_pkg::met_rsp_type                 rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [met_pkg::CSR_ADDR_W-1:0]       csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import met_pkg::*;

   localparam int CW    = COORD_WIDTH;
   localparam int MUL_W = (CW > STEP_W + 1) ? CW : STEP_W + 1;
   localparam int PW    = 2 * MUL_W;
   localparam int SW    = (PW + 2 > 2 * FRAC_BITS + 4) ? PW + 2 : 2 * FRAC_BITS + 4;

   // configuration
   logic signed [CSR_DATA_W-1:0] center_x_ff, center_y_ff;
   logic [STEP_W-1:0]            step_ff;
   logic [COUNT_W-1:0]           limit_ff;
   logic [SIZE_W-1:0]            width_ff, height_ff;

   met_state_type state_ff, state_in;

   logic [PIXEL_W-1:0]    column_ff, column_in, row_ff, row_in;
   logic signed [CW-1:0]  cr_ff, cr_in, ci_ff, ci_in, zr_ff, zr_in, zi_ff, zi_in;
   logic signed [PW-1:0]  prod_ff, prod_in, sr_ff, sr_in, si_ff, si_in;
   logic [COUNT_W-1:0]    n_ff, n_in, n_inc;
   logic                  rsp_valid_ff, rsp_valid_in;
   met_rsp_type           rsp_data_ff, rsp_data_in;

   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [PW-1:0]    mul_p;
   logic signed [OFFS_W-1:0] dx, dy;
   logic signed [SW-1:0]    map_re_sum, map_im_sum, mag_sum, new_re_sum, new_im_sum;
   logic signed [SW-1:0]    thr;
   logic                    escaped, out_free, req_take;

   function automatic logic signed [CW-1:0] sat(input logic signed [SW-1:0] v);
      logic [SW-CW:0] upper;
      logic signed [CW-1:0] r;
      upper = v[SW-1:CW-1];
      if (upper == '0 || upper == '1) begin
         r = v[CW-1:0];
      end else if (v[SW-1]) begin
         r = {1'b1, {(CW-1){1'b0}}};
      end else begin
         r = {1'b0, {(CW-1){1'b1}}};
      end
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         step_ff     <= RST_PIXEL_STEP;
         limit_ff    <= RST_ITER_LIMIT;
         width_ff    <= RST_SCREEN_W;
         height_ff   <= RST_SCREEN_H;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CENTER_X:   center_x_ff <= csr_wdata;
            CSR_CENTER_Y:   center_y_ff <= csr_wdata;
            CSR_PIXEL_STEP: step_ff     <= csr_wdata[STEP_W-1:0];
            CSR_ITER_LIMIT: limit_ff    <= csr_wdata[COUNT_W-1:0];
            CSR_SCREEN_W:   width_ff    <= csr_wdata[SIZE_W-1:0];
            CSR_SCREEN_H:   height_ff   <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier, registered into prod_ff
   assign dx    = $signed({2'b00, column_ff}) - $signed({2'b00, width_ff[SIZE_W-1:1]});
   assign dy    = $signed({2'b00, height_ff[SIZE_W-1:1]}) - $signed({2'b00, row_ff});
   assign mul_p = mul_a * mul_b;

   assign map_re_sum = SW'(prod_ff) + SW'(center_x_ff);
   assign map_im_sum = SW'(prod_ff) - SW'(center_y_ff);
   assign mag_sum    = SW'(sr_ff) + SW'(si_ff);
   assign thr        = SW'(1) <<< (2 * FRAC_BITS + 2);
   assign escaped    = !(mag_sum < thr);
   // floor shifts; prod_ff holds zr*zi in the update cycle
   assign new_im_sum = (SW'(prod_ff) >>> (FRAC_BITS - 1)) + SW'(ci_ff);
   assign new_re_sum = ((SW'(sr_ff) - SW'(si_ff)) >>> FRAC_BITS) + SW'(cr_ff);
   assign n_inc      = n_ff + COUNT_W'(1);

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      column_in    = column_ff;
      row_in       = row_ff;
      cr_in        = cr_ff;
      ci_in        = ci_ff;
      zr_in        = zr_ff;
      zi_in        = zi_ff;
      prod_in      = prod_ff;
      sr_in        = sr_ff;
      si_in        = si_ff;
      n_in         = n_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      mul_a        = '0;
      mul_b        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               column_in = req_data.column;
               row_in    = req_data.row;
               zr_in     = '0;
               zi_in     = '0;
               n_in      = '0;
               state_in  = ST_MAP_RE;
            end
         end
         ST_MAP_RE: begin
            mul_a    = MUL_W'(dx);
            mul_b    = $signed(MUL_W'(step_ff));
            prod_in  = mul_p;
            state_in = ST_MAP_IM;
         end
         ST_MAP_IM: begin
            cr_in    = sat(map_re_sum);
            mul_a    = MUL_W'(dy);
            mul_b    = $signed(MUL_W'(step_ff));
            prod_in  = mul_p;
            state_in = ST_MAP_FIN;
         end
         ST_MAP_FIN: begin
            ci_in    = sat(map_im_sum);
            state_in = ST_SQ_RE;
            // zero limit: finish without iterating
            if (limit_ff == '0 && out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.iterations = '0;
               rsp_data_in.in_set     = 1'b1;
               state_in               = ST_IDLE;
            end else if (limit_ff == '0) begin
               state_in = ST_MAP_FIN;
            end
         end
         ST_SQ_RE: begin
            mul_a    = MUL_W'(zr_ff);
            mul_b    = MUL_W'(zr_ff);
            prod_in  = mul_p;
            state_in = ST_SQ_IM;
         end
         ST_SQ_IM: begin
            sr_in    = prod_ff;
            mul_a    = MUL_W'(zi_ff);
            mul_b    = MUL_W'(zi_ff);
            prod_in  = mul_p;
            state_in = ST_CROSS;
         end
         ST_CROSS: begin
            si_in    = prod_ff;
            mul_a    = MUL_W'(zr_ff);
            mul_b    = MUL_W'(zi_ff);
            prod_in  = mul_p;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (escaped) begin
               // hold here until the output register frees up
               if (out_free) begin
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.iterations = n_ff;
                  rsp_data_in.in_set     = (n_ff == limit_ff);
                  state_in               = ST_IDLE;
               end
            end else if (n_inc == limit_ff) begin
               if (out_free) begin
                  zr_in                  = sat(new_re_sum);
                  zi_in                  = sat(new_im_sum);
                  n_in                   = n_inc;
                  rsp_valid_in           = 1'b1;
                  rsp_data_in.iterations = n_inc;
                  rsp_data_in.in_set     = 1'b1;
                  state_in               = ST_IDLE;
               end
            end else begin
               zr_in    = sat(new_re_sum);
               zi_in    = sat(new_im_sum);
               n_in     = n_inc;
               state_in = ST_SQ_RE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         n_ff         <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         n_ff         <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      column_ff   <= column_in;
      row_ff      <= row_in;
      cr_ff       <= cr_in;
      ci_ff       <= ci_in;
      zr_ff       <= zr_in;
      zi_ff       <= zi_in;
      prod_ff     <= prod_in;
      sr_ff       <= sr_in;
      si_ff       <= si_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_take_starts_map: assert property (@(posedge clock) disable iff (reset)
      req_take |=> state_ff == ST_MAP_RE)
      else $error("accepted request did not start mapping");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQ_RE || state_ff == ST_UPDATE) |-> n_ff < limit_ff)
      else $error("iteration count ran past the limit");

   a_in_set_flag: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> rsp_data_ff.in_set == (rsp_data_ff.iterations == limit_ff))
      else $error("in-set flag disagrees with the count");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && rsp_data_ff == $past(rsp_data_ff))
      else $error("pending result overwritten");

endmodule

FILE: tb/sv/escape_time_checker.sv
`timescale 1ns / 100ps

module escape_time_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  met_pkg::met_req_type           req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  met_pkg::met_rsp_type           rsp_data,
   input  logic                           csr_wr_en,
   input  logic [met_pkg::CSR_ADDR_W-1:0] csr_index,
   input  logic [met_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int unsigned                    mismatches,
   output int unsigned                    in_flight
);
   import met_pkg::*;

   localparam int FRAC_BITS = 28;
   localparam logic signed [127:0] COORD_MAX  = (128'sd1 <<< 31) - 128'sd1;
   localparam logic signed [127:0] COORD_MIN  = -(128'sd1 <<< 31);
   localparam logic signed [127:0] ESCAPE_MAG = 128'sd4 <<< (2 * FRAC_BITS);
   localparam int unsigned REPORT_LIMIT = 10;

   // shadow of the view registers
   logic signed [31:0]  center_x;
   logic signed [31:0]  center_y;
   logic [STEP_W-1:0]   pixel_step;
   logic [COUNT_W-1:0]  iter_limit;
   logic [SIZE_W-1:0]   screen_w;
   logic [SIZE_W-1:0]   screen_h;

   met_rsp_type pending_counts[$];

   function automatic logic signed [127:0] saturate(input logic signed [127:0] v);
      if (v < COORD_MIN) return COORD_MIN;
      if (v > COORD_MAX) return COORD_MAX;
      return v;
   endfunction

   function automatic met_rsp_type escape_count(input met_req_type px);
      longint              col_v, row_v, half_w, half_h, step_v, cx_v, cy_v;
      logic signed [127:0] cr, ci, zr, zi, zi_next, sq_re, sq_im;
      int unsigned         n;
      met_rsp_type         r;
      col_v  = longint'(px.column);
      row_v  = longint'(px.row);
      half_w = longint'(screen_w >> 1);
      half_h = longint'(screen_h >> 1);
      step_v = longint'(pixel_step);
      cx_v   = longint'(center_x);
      cy_v   = longint'(center_y);
      cr = saturate(128'((col_v - half_w) * step_v + cx_v));
      ci = saturate(128'((half_h - row_v) * step_v - cy_v));
      zr = '0;
      zi = '0;
      n  = 0;
      while (n != iter_limit) begin
         sq_re = zr * zr;
         sq_im = zi * zi;
         if (sq_re + sq_im >= ESCAPE_MAG) break;
         // 2*zr*zi: drop one bit less than the fraction width
         zi_next = saturate(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
         zr      = saturate(((sq_re - sq_im) >>> FRAC_BITS) + cr);
         zi      = zi_next;
         n++;
      end
      r.iterations = n[COUNT_W-1:0];
      r.in_set     = (n == iter_limit);
      return r;
   endfunction

   always @(posedge clock) begin : monitor
      met_rsp_type want;
      if (reset) begin
         center_x   = '0;
         center_y   = '0;
         pixel_step = RST_PIXEL_STEP;
         iter_limit = RST_ITER_LIMIT;
         screen_w   = RST_SCREEN_W;
         screen_h   = RST_SCREEN_H;
         pending_counts.delete();
         mismatches <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_counts.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: response with no request pending: iterations %0d in_set %0b",
                           $time, rsp_data.iterations, rsp_data.in_set);
               mismatches <= mismatches + 1;
            end else begin
               want = pending_counts.pop_front();
               if (rsp_data.iterations !== want.iterations ||
                   rsp_data.in_set !== want.in_set) begin
                  if (mismatches < REPORT_LIMIT)
                     $display("%0t: expected iterations %0d in_set %0b, got iterations %0d in_set %0b",
                              $time, want.iterations, want.in_set,
                              rsp_data.iterations, rsp_data.in_set);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_counts.push_back(escape_count(req_data));
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CENTER_X:   center_x   = csr_wdata;
               CSR_CENTER_Y:   center_y   = csr_wdata;
               CSR_PIXEL_STEP: pixel_step = csr_wdata[STEP_W-1:0];
               CSR_ITER_LIMIT: iter_limit = csr_wdata[COUNT_W-1:0];
               CSR_SCREEN_W:   screen_w   = csr_wdata[SIZE_W-1:0];
               CSR_SCREEN_H:   screen_h   = csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
      end
      in_flight <= pending_counts.size();
   end

endmodule

FILE: tb/sv/mandelbrot_escape_time_unit_test.sv
`timescale 1ns / 100ps

module mandelbrot_escape_time_unit_test;
   import met_pkg::*;

   localparam int unsigned WATCHDOG_CYCLES = 1000000;
   localparam int unsigned HOLD_OFF_CYCLES = 2500;
   localparam int unsigned SETTLE_CYCLES   = 64;
   localparam int unsigned RANDOM_VIEWS    = 13;
   localparam int unsigned PIXELS_PER_VIEW = 110;
   // a point on the boundary of the set, Q4.28
   localparam int ZOOM_RE = -199599730;
   localparam int ZOOM_IM = 35273035;

   typedef struct {
      logic [31:0]        center_x;
      logic [31:0]        center_y;
      logic [STEP_W-1:0]  pixel_step;
      logic [COUNT_W-1:0] iter_limit;
      logic [SIZE_W-1:0]  screen_w;
      logic [SIZE_W-1:0]  screen_h;
   } view_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   met_req_type           req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   met_rsp_type           rsp_data;
   logic                  csr_wr_en;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int unsigned           mismatches;
   int unsigned           in_flight;
   bit                    quiet = 1'b1;
   bit                    hold_off_pending = 1'b0;

   mandelbrot_escape_time_unit dut (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wdata
   );

   escape_time_checker escape_check (
      .clock, .reset,
      .req_valid, .req_stall, .req_data,
      .rsp_valid, .rsp_stall, .rsp_data,
      .csr_wr_en, .csr_index, .csr_wdata,
      .mismatches, .in_flight
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   initial begin : watchdog
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_CYCLES) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("timeout: no handshake for %0d cycles", WATCHDOG_CYCLES);
      $display("TB_ERROR");
      $finish;
   end

   // result side: random stalls, or one long hold-off on request
   initial begin : receiver
      int unsigned ready_len, stall_len, roll;
      forever begin
         rsp_stall <= 1'b0;
         ready_len = $urandom_range(1, 8);
         repeat (ready_len) @(posedge clock);
         roll = $urandom_range(0, 99);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            stall_len = HOLD_OFF_CYCLES;
         end else if (quiet || roll < 45)
            stall_len = 0;
         else if (roll < 90)
            stall_len = $urandom_range(1, 4);
         else
            stall_len = $urandom_range(20, 150);
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
      end
   end

   function automatic met_req_type pixel_at(input int unsigned col, input int unsigned row);
      met_req_type px;
      px.column = col[PIXEL_W-1:0];
      px.row    = row[PIXEL_W-1:0];
      return px;
   endfunction

   function automatic logic [PIXEL_W-1:0] pick_coord(input logic [SIZE_W-1:0] size);
      if (size == 0 || size > 1024 || $urandom_range(0, 4) == 0)
         return PIXEL_W'($urandom_range(0, 1023));
      return PIXEL_W'($urandom_range(0, size - 1));
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 93) return $urandom_range(1, 4);
      return $urandom_range(20, 120);
   endfunction

   task automatic load_view(input view_type v);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_CENTER_X;   csr_wdata <= v.center_x;   @(posedge clock);
      csr_index <= CSR_CENTER_Y;   csr_wdata <= v.center_y;   @(posedge clock);
      csr_index <= CSR_PIXEL_STEP; csr_wdata <= CSR_DATA_W'(v.pixel_step); @(posedge clock);
      csr_index <= CSR_ITER_LIMIT; csr_wdata <= CSR_DATA_W'(v.iter_limit); @(posedge clock);
      csr_index <= CSR_SCREEN_W;   csr_wdata <= CSR_DATA_W'(v.screen_w);   @(posedge clock);
      csr_index <= CSR_SCREEN_H;   csr_wdata <= CSR_DATA_W'(v.screen_h);   @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // offer one request after an optional gap, return at the edge that takes it
   task automatic send_pixel(input met_req_type px, input int unsigned gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   function automatic view_type default_view();
      view_type v;
      v.center_x   = '0;
      v.center_y   = '0;
      v.pixel_step = RST_PIXEL_STEP;
      v.iter_limit = RST_ITER_LIMIT;
      v.screen_w   = RST_SCREEN_W;
      v.screen_h   = RST_SCREEN_H;
      return v;
   endfunction

   task automatic run_directed();
      view_type v;
      // nothing written yet: the centre pixel sits at the origin
      send_pixel(pixel_at(320, 240), 0);
      send_pixel(pixel_at(0, 0), 0);
      send_pixel(pixel_at(1023, 1023), 0);
      send_pixel(pixel_at(1023, 0), 0);
      send_pixel(pixel_at(0, 1023), 0);
      send_pixel(pixel_at(100, 240), 0);
      send_pixel(pixel_at(200, 150), 0);
      wait_drained();

      // zero limit: no iteration is done
      v = default_view();
      v.iter_limit = '0;
      load_view(v);
      send_pixel(pixel_at(320, 240), 0);
      send_pixel(pixel_at(0, 0), 0);
      wait_drained();

      // zero step: every pixel lands on the centre
      v = default_view();
      v.pixel_step = '0;
      v.iter_limit = 16'd50;
      load_view(v);
      send_pixel(pixel_at(0, 0), 0);
      send_pixel(pixel_at(1023, 1023), 0);
      wait_drained();

      // extreme centre and step: the starting point saturates both ways
      v.center_x   = 32'h7FFF_FFFF;
      v.center_y   = 32'h8000_0000;
      v.pixel_step = '1;
      v.iter_limit = 16'd5;
      v.screen_w   = 11'd2047;
      v.screen_h   = 11'd0;
      load_view(v);
      send_pixel(pixel_at(0, 0), 0);
      send_pixel(pixel_at(1023, 1023), 0);
      send_pixel(pixel_at(1023, 0), 0);
      wait_drained();

      // sizes outside the usual range are halved as they are
      v.center_x   = 32'hF800_0000;
      v.center_y   = '0;
      v.pixel_step = 28'd786432;
      v.iter_limit = 16'd30;
      v.screen_w   = 11'd0;
      v.screen_h   = 11'd2047;
      load_view(v);
      send_pixel(pixel_at(0, 0), 0);
      send_pixel(pixel_at(1023, 1023), 0);
      send_pixel(pixel_at(512, 512), 0);
      wait_drained();

      // largest limit: the origin runs the full count
      v = default_view();
      v.iter_limit = '1;
      load_view(v);
      send_pixel(pixel_at(320, 240), 0);
      send_pixel(pixel_at(0, 0), 0);
      wait_drained();
   endtask

   task automatic run_random_view(input int unsigned count, input bit squeeze);
      view_type    v;
      met_req_type px;
      int unsigned kind;
      kind = squeeze ? 0 : $urandom_range(0, 9);
      if (kind < 6) begin
         // centre near the set, coarse pixel step
         v.center_x   = $urandom_range(0, 32'd268435456) - 32'd268435456;
         v.center_y   = $urandom_range(0, 32'd134217728) - 32'd67108864;
         v.pixel_step = STEP_W'($urandom_range(32'd65536, 32'd1048576));
         v.iter_limit = COUNT_W'($urandom_range(1, 64));
         v.screen_w   = ($urandom_range(0, 2) == 0) ? SIZE_W'($urandom_range(1, 1024)) : 11'd1024;
         v.screen_h   = ($urandom_range(0, 2) == 0) ? SIZE_W'($urandom_range(1, 1024)) : 11'd1024;
      end else if (kind < 8) begin
         // close in on the boundary, where counts run long
         v.center_x   = ZOOM_RE + $urandom_range(0, 4095);
         v.center_y   = ZOOM_IM + $urandom_range(0, 4095);
         v.pixel_step = STEP_W'($urandom_range(1, 4096));
         v.iter_limit = COUNT_W'($urandom_range(64, 300));
         v.screen_w   = 11'd1024;
         v.screen_h   = ($urandom_range(0, 1) == 0) ? SIZE_W'($urandom_range(1, 1024)) : 11'd1024;
      end else begin
         v.center_x   = $urandom;
         v.center_y   = $urandom;
         v.pixel_step = STEP_W'($urandom_range(1, 32'h0FFF_FFFF));
         v.iter_limit = COUNT_W'($urandom_range(0, 100));
         v.screen_w   = SIZE_W'($urandom_range(0, 2047));
         v.screen_h   = SIZE_W'($urandom_range(0, 2047));
      end
      load_view(v);
      quiet = squeeze || ($urandom_range(0, 3) == 0);
      if (squeeze) hold_off_pending = 1'b1;
      for (int unsigned i = 0; i < count; i++) begin
         px.column = pick_coord(v.screen_w);
         px.row    = pick_coord(v.screen_h);
         send_pixel(px, squeeze ? 0 : pick_gap());
         // pause the sender until every result is back
         if (i == count / 2) wait_drained();
      end
      wait_drained();
   endtask

   initial begin : stimulus
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_wr_en <= 1'b0;
      csr_index <= CSR_CENTER_X;
      csr_wdata <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int unsigned k = 0; k < RANDOM_VIEWS; k++)
         run_random_view(PIXELS_PER_VIEW, k == 1);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && in_flight == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: mandelbrot_escape_time_unit.f
rtl/core/met_pkg.sv
rtl/core/mandelbrot_escape_time_unit.sv
tb/sv/escape_time_checker.sv
tb/sv/mandelbrot_escape_time_unit_test.sv
